[rtl/ordered_queue_remove_by_key_macros.svh]
// Assertion macros for the ordered queue with remove by key.
// Used by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef ORDERED_QUEUE_REMOVE_BY_KEY_MACROS_SVH
`define ORDERED_QUEUE_REMOVE_BY_KEY_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset aware.
`define OQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset aware.
`define OQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define OQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/oq_pkg.sv]
// Shared types and constants for the ordered queue with remove by key.
// No dependencies; imported by the interfaces, the cell and the top level.
`default_nettype none

package oq_pkg;

  localparam int unsigned CapacityDef = 64;

  localparam int unsigned IdW    = 31;
  localparam int unsigned PriceW = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              side;
    logic [PriceW-1:0] price;
    logic [TimeW-1:0]  stamp;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic capture;   // word accepted: latch key compare
    logic remove;    // execute cycle of a remove
    logic append;    // execute cycle of an append
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/oq_in_if.sv]
// Input channel of the ordered queue: valid/ready plus the operation word.
// Depends on oq_pkg for field widths.
`default_nettype none

interface oq_in_if;
  import oq_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [IdW-1:0]    key_id;
  logic              side;
  logic [PriceW-1:0] price_ticks;
  logic [TimeW-1:0]  arrival_time;

  modport source (
    output valid, opcode, key_id, side, price_ticks, arrival_time,
    input  ready
  );

  modport sink (
    input  valid, opcode, key_id, side, price_ticks, arrival_time,
    output ready
  );
endinterface

`default_nettype wire

[rtl/oq_out_if.sv]
// Result channel of the ordered queue: valid/ready plus the result word.
// Depends on oq_pkg for field widths.
`default_nettype none

interface oq_out_if;
  import oq_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [CountW-1:0] entry_count;
  logic              head_valid;
  logic [IdW-1:0]    head_id;
  logic              head_side;
  logic [PriceW-1:0] head_price;
  logic [TimeW-1:0]  head_time;

  modport source (
    output valid, ok, entry_count, head_valid, head_id, head_side, head_price,
           head_time,
    input  ready
  );

  modport sink (
    input  valid, ok, entry_count, head_valid, head_id, head_side, head_price,
           head_time,
    output ready
  );
endinterface

`default_nettype wire

[rtl/oq_cell.sv]
// One queue slot: holds an entry, compares its id, shifts from its right neighbor or loads an append.
// Depends on oq_pkg.
`default_nettype none

module oq_cell #(
  parameter int unsigned CAPACITY = oq_pkg::CapacityDef,
  parameter int unsigned INDEX    = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire oq_pkg::cell_ctl_t                   ctl_i,
  input  wire logic [oq_pkg::IdW-1:0]              key_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]       fill_i,
  input  wire oq_pkg::entry_t                      new_entry_i,
  input  wire oq_pkg::entry_t                      next_entry_i,
  input  wire logic                                hit_i,
  output logic                                     hit_o,
  output oq_pkg::entry_t                           entry_o,
  output oq_pkg::entry_t                           entry_d_o
);
  import oq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] IdxC = CW'(INDEX);

  entry_t entry_q, entry_d;
  logic   match_q, match_d;

  // Compare at accept time; only occupied slots may match.
  assign match_d = (IdxC < fill_i) && (entry_q.id == key_i);

  // Prefix OR along the chain: this slot or an older one holds the key.
  assign hit_o = hit_i | match_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.remove && hit_o) begin
      entry_d = next_entry_i;
    end else if (ctl_i.append && (fill_i == IdxC)) begin
      entry_d = new_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.capture) begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

`default_nettype wire

[rtl/ordered_queue_remove_by_key.sv]
// Ordered queue with remove by key: an accepted word runs in the execute state, then its result word
// is registered; a new word is taken only after the compare step and then the ripple/shift step.
// Result sits in an output register; the next word is taken while it drains.
// Reset (async, active low) empties the queue; slot contents are not cleared.
`default_nettype none
`include "ordered_queue_remove_by_key_macros.svh"

module ordered_queue_remove_by_key #(
  parameter int unsigned CAPACITY = oq_pkg::CapacityDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  oq_in_if.sink     in_i,
  oq_out_if.source  out_o
);
  import oq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  op_e             op_q;
  entry_t          new_q;          // appended entry, latched at accept
  logic [CW-1:0]   fill_q, fill_d;

  logic            in_fire;
  logic            exec;
  logic            full;
  logic            ok;
  cell_ctl_t       ctl;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              res_ok_q;
  logic [CountW-1:0] res_count_q;
  logic              res_head_valid_q;
  entry_t            res_head_q;

  // ---------------------------------------------------------------------------
  // Cell chain: slot 0 is the head. hit ripples toward the tail; on a remove
  // every slot at or past the first match pulls its right neighbor's entry.
  // ---------------------------------------------------------------------------
  logic   [CAPACITY:0]   hit;
  entry_t [CAPACITY-1:0] cell_q;
  entry_t [CAPACITY-1:0] cell_d;

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t next_entry;
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = cell_q[g];
    end else begin : g_mid
      assign next_entry = cell_q[g+1];
    end

    oq_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (in_i.key_id),
      .fill_i       (fill_q),
      .new_entry_i  (new_q),
      .next_entry_i (next_entry),
      .hit_i        (hit[g]),
      .hit_o        (hit[g+1]),
      .entry_o      (cell_q[g]),
      .entry_d_o    (cell_d[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake and sequencing
  // ---------------------------------------------------------------------------
  // Take a word only when idle and the result slot is free or draining now.
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign exec       = (state_q == ST_EXEC);

  assign full = (fill_q == CapC);
  assign ok   = (op_q == OP_REMOVE) ? hit[CAPACITY] : !full;

  always_comb begin
    ctl.capture = in_fire;
    ctl.remove  = exec && (op_q == OP_REMOVE);
    ctl.append  = exec && (op_q == OP_APPEND);
  end

  always_comb begin
    fill_d = fill_q;
    if (exec && ok) begin
      if (op_q == OP_REMOVE) begin
        fill_d = fill_q - CW'(1);
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation word latched at accept (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= op_e'(in_i.opcode);
      new_q.id    <= in_i.key_id;
      new_q.side  <= in_i.side;
      new_q.price <= in_i.price_ticks;
      new_q.stamp <= in_i.arrival_time;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word: count and head taken from the post-operation state
  // ---------------------------------------------------------------------------
  logic [CW+CountW-1:0] fill_wide;
  assign fill_wide = {{CountW{1'b0}}, fill_d};

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_ok_q         <= ok;
      res_count_q      <= fill_wide[CountW-1:0];   // modulo 128 for large queues
      res_head_valid_q <= (fill_d != '0);
      res_head_q       <= (fill_d != '0) ? cell_d[0] : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = res_ok_q;
  assign out_o.entry_count = res_count_q;
  assign out_o.head_valid  = res_head_valid_q;
  assign out_o.head_id     = res_head_q.id;
  assign out_o.head_side   = res_head_q.side;
  assign out_o.head_price  = res_head_q.price;
  assign out_o.head_time   = res_head_q.stamp;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `OQ_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CapC,
                  "fill count above capacity")
  `OQ_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == ST_IDLE,
                  "ready outside idle")
  `OQ_ASSERT_NEXT(a_exec_result, clk_i, rst_ni, exec, out_valid_q && state_q == ST_IDLE,
                  "execute cycle did not load a result")
  `OQ_ASSERT_NEXT(a_remove_count, clk_i, rst_ni, ctl.remove && hit[CAPACITY],
                  fill_q == $past(fill_q) - CW'(1), "remove hit did not shrink queue")
  `OQ_ASSERT_IMPL(a_remove_nonempty, clk_i, rst_ni, ctl.remove && hit[CAPACITY],
                  fill_q != '0, "remove hit on empty queue")

endmodule

`default_nettype wire
